// ----- sv/frg_pkg.sv -----
package frg_pkg;

   localparam int VALUE_WIDTH = 16;
   localparam int CNT_WIDTH = $clog2(VALUE_WIDTH);
   localparam int REQ_DATA_WIDTH = ((2 * VALUE_WIDTH + 7) / 8) * 8;
   localparam int RSP_DATA_WIDTH = ((3 * VALUE_WIDTH + 7) / 8) * 8;

   typedef logic [VALUE_WIDTH-1:0] value_type;

   // handshake from the gcd unit back to the sequencer
   typedef struct packed {
      logic      done;
      value_type divisor;
   } gcd_status_type;

endpackage

// ----- sv/frg_cell.sv -----
module frg_cell (
   input  logic clock,
   input  logic load,
   input  logic step,
   input  logic load_q,
   input  logic load_d,
   input  logic shift_r,
   input  logic shift_q,
   input  logic borrow_in,
   input  logic take,
   output logic r_out,
   output logic q_out,
   output logic borrow_out
);

   logic r_ff;
   logic q_ff;
   logic d_ff;
   logic diff;

   // one bit of the trial subtract, shifted remainder minus divisor
   assign diff = shift_r ^ d_ff ^ borrow_in;
   assign borrow_out = (~shift_r & d_ff) | (~(shift_r ^ d_ff) & borrow_in);

   always_ff @(posedge clock) begin
      if (load) begin
         r_ff <= 1'b0;
         q_ff <= load_q;
         d_ff <= load_d;
      end else if (step) begin
         r_ff <= take ? diff : shift_r;
         q_ff <= shift_q;
      end
   end

   assign r_out = r_ff;
   assign q_out = q_ff;

endmodule

// ----- sv/frg_div_row.sv -----
module frg_div_row (
   input  logic              clock,
   input  logic              load,
   input  logic              step,
   input  frg_pkg::value_type dividend,
   input  frg_pkg::value_type divisor,
   output frg_pkg::value_type quotient
);

   localparam int W = frg_pkg::VALUE_WIDTH;

   logic [W-1:0] r_bit;
   logic [W-1:0] q_bit;
   logic [W-1:0] borrow;
   logic [W-1:0] shift_r;
   logic [W-1:0] shift_q;
   logic [W-1:0] borrow_in;
   logic         take;

   // restore unless the trial went negative; the bit shifted out on top always fits
   assign take = r_bit[W-1] | ~borrow[W-1];

   assign shift_r[0]   = q_bit[W-1];
   assign shift_q[0]   = take;
   assign borrow_in[0] = 1'b0;

   for (genvar i = 1; i < W; i++) begin : g_link
      assign shift_r[i]   = r_bit[i-1];
      assign shift_q[i]   = q_bit[i-1];
      assign borrow_in[i] = borrow[i-1];
   end

   for (genvar i = 0; i < W; i++) begin : g_cell
      frg_cell u_cell (
         .clock      (clock),
         .load       (load),
         .step       (step),
         .load_q     (dividend[i]),
         .load_d     (divisor[i]),
         .shift_r    (shift_r[i]),
         .shift_q    (shift_q[i]),
         .borrow_in  (borrow_in[i]),
         .take       (take),
         .r_out      (r_bit[i]),
         .q_out      (q_bit[i]),
         .borrow_out (borrow[i])
      );
   end

   assign quotient = q_bit;

endmodule

// ----- sv/frg_gcd.sv -----
module frg_gcd (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  frg_pkg::value_type     operand_a,
   input  frg_pkg::value_type     operand_b,
   output frg_pkg::gcd_status_type status
);

   localparam int W = frg_pkg::VALUE_WIDTH;

   frg_pkg::value_type             a_ff;
   frg_pkg::value_type             b_ff;
   logic [frg_pkg::CNT_WIDTH-1:0]  k_ff;
   logic                           busy_ff;
   logic [W:0]                     diff_ab;
   logic [W:0]                     diff_ba;
   logic                           equal;

   assign diff_ab = {1'b0, a_ff} - {1'b0, b_ff};
   assign diff_ba = {1'b0, b_ff} - {1'b0, a_ff};
   assign equal   = (a_ff == b_ff);

   // binary gcd: strip shared twos into k, then odd differences halved
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (start) begin
         a_ff    <= operand_a;
         b_ff    <= operand_b;
         k_ff    <= '0;
         busy_ff <= 1'b1;
      end else if (busy_ff) begin
         if (equal) begin
            busy_ff <= 1'b0;
         end else if (!a_ff[0] && !b_ff[0]) begin
            a_ff <= a_ff >> 1;
            b_ff <= b_ff >> 1;
            k_ff <= k_ff + frg_pkg::CNT_WIDTH'(1);
         end else if (!a_ff[0]) begin
            a_ff <= a_ff >> 1;
         end else if (!b_ff[0]) begin
            b_ff <= b_ff >> 1;
         end else if (!diff_ab[W]) begin
            a_ff <= diff_ab[W:1];
         end else begin
            b_ff <= diff_ba[W:1];
         end
      end
   end

   assign status.done    = busy_ff & equal;
   assign status.divisor = a_ff << k_ff;

   a_done_has_divisor: assert property (@(posedge clock) disable iff (reset)
      status.done |-> status.divisor != '0)
      else $error("gcd finished with a zero divisor");

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start |=> busy_ff)
      else $error("gcd did not start");

   a_done_ends: assert property (@(posedge clock) disable iff (reset)
      status.done && !start |=> !busy_ff)
      else $error("gcd still busy after done");

endmodule

// ----- sv/fraction_reduce_gcd_core.sv -----
// fraction reduction to lowest terms
//
// req channel: one word carries numerator (low bits) and denominator (next
// bits); req_tready is high only while the core is idle, one fraction at a time.
// rsp channel: reduced numerator, reduced denominator and the common divisor
// in rsp_tdata, bad_operand in rsp_tuser. a zero numerator or denominator
// gives bad_operand set, divisor zero and both parts passed through.
// the core takes the word, runs the binary gcd, then divides in the two rows
// of divider cells (numerator and denominator divided side by side, one
// quotient bit per cycle) and loads the result into the output register. a bad
// operand skips the gcd and the divider rows and goes straight to the output.
// the output register lets the core take the next word while a result waits;
// a stalled rsp side holds the finished result in the core until it is free.
// reset (synchronous, active high) empties the output register and returns
// the core to idle; no state is kept between fractions.
module fraction_reduce_gcd_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // numerator, denominator
   input  logic [frg_pkg::REQ_DATA_WIDTH-1:0] req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // reduced_numerator, reduced_denominator, common_divisor
   output logic [frg_pkg::RSP_DATA_WIDTH-1:0] rsp_tdata,
   // bad_operand
   output logic                              rsp_tuser
);

   localparam int W = frg_pkg::VALUE_WIDTH;

   typedef enum logic [1:0] {
      S_IDLE,
      S_GCD,
      S_DIV,
      S_DONE
   } state_type;

   state_type                      state_ff;
   frg_pkg::value_type             num_ff;
   frg_pkg::value_type             den_ff;
   frg_pkg::value_type             div_ff;
   logic                           bad_ff;
   logic [frg_pkg::CNT_WIDTH-1:0]  cnt_ff;
   logic                           rsp_valid_ff;
   frg_pkg::value_type             rsp_num_ff;
   frg_pkg::value_type             rsp_den_ff;
   frg_pkg::value_type             rsp_div_ff;
   logic                           rsp_bad_ff;

   frg_pkg::value_type             num_in;
   frg_pkg::value_type             den_in;
   logic                           accept;
   logic                           gcd_start;
   frg_pkg::gcd_status_type        gcd_status;
   logic                           div_load;
   logic                           div_step;
   frg_pkg::value_type             quot_num;
   frg_pkg::value_type             quot_den;
   logic                           out_free;

   assign num_in     = req_tdata[W-1:0];
   assign den_in     = req_tdata[2*W-1:W];
   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid & req_tready;
   assign gcd_start  = accept & (num_in != '0) & (den_in != '0);
   assign div_load   = (state_ff == S_GCD) & gcd_status.done;
   assign div_step   = (state_ff == S_DIV);
   assign out_free   = ~rsp_valid_ff | rsp_tready;

   frg_gcd u_gcd (
      .clock     (clock),
      .reset     (reset),
      .start     (gcd_start),
      .operand_a (num_in),
      .operand_b (den_in),
      .status    (gcd_status)
   );

   frg_div_row u_row_num (
      .clock    (clock),
      .load     (div_load),
      .step     (div_step),
      .dividend (num_ff),
      .divisor  (gcd_status.divisor),
      .quotient (quot_num)
   );

   frg_div_row u_row_den (
      .clock    (clock),
      .load     (div_load),
      .step     (div_step),
      .dividend (den_ff),
      .divisor  (gcd_status.divisor),
      .quotient (quot_den)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         // S_DONE refills the output register on its own
         if (rsp_valid_ff && rsp_tready && (state_ff != S_DONE)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  num_ff   <= num_in;
                  den_ff   <= den_in;
                  bad_ff   <= ~gcd_start;
                  state_ff <= gcd_start ? S_GCD : S_DONE;
               end
            end
            S_GCD: begin
               if (gcd_status.done) begin
                  div_ff   <= gcd_status.divisor;
                  cnt_ff   <= frg_pkg::CNT_WIDTH'(W - 1);
                  state_ff <= S_DIV;
               end
            end
            S_DIV: begin
               cnt_ff <= cnt_ff - frg_pkg::CNT_WIDTH'(1);
               if (cnt_ff == '0) begin
                  state_ff <= S_DONE;
               end
            end
            S_DONE: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_num_ff   <= bad_ff ? num_ff : quot_num;
                  rsp_den_ff   <= bad_ff ? den_ff : quot_den;
                  rsp_div_ff   <= bad_ff ? '0 : div_ff;
                  rsp_bad_ff   <= bad_ff;
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = frg_pkg::RSP_DATA_WIDTH'({rsp_div_ff, rsp_den_ff, rsp_num_ff});
   assign rsp_tuser  = rsp_bad_ff;

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_tready)
      else $error("second word taken while a fraction is in flight");

   a_bad_zero_divisor: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_bad_ff |-> rsp_div_ff == '0)
      else $error("bad operand result carries a divisor");

   a_good_divisor: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_bad_ff |-> rsp_div_ff != '0)
      else $error("reduced result with zero divisor");

   a_gcd_in_state: assert property (@(posedge clock) disable iff (reset)
      gcd_status.done |-> state_ff == S_GCD)
      else $error("gcd finished outside its phase");

endmodule

// ----- test/testbench.sv -----
module testbench;

   typedef struct {
      frg_pkg::value_type numerator;
      frg_pkg::value_type denominator;
      frg_pkg::value_type divisor;
      logic               bad_operand;
   } reduced_fraction_type;

   class reduction_scoreboard;
      reduced_fraction_type expected_reductions[$];
      int                   error_count = 0;

      function reduced_fraction_type reduce_fraction(frg_pkg::value_type num,
                                                     frg_pkg::value_type den);
         reduced_fraction_type r;
         frg_pkg::value_type   a;
         frg_pkg::value_type   b;
         frg_pkg::value_type   t;
         if (num == '0 || den == '0) begin
            r.numerator   = num;
            r.denominator = den;
            r.divisor     = '0;
            r.bad_operand = 1'b1;
         end else begin
            a = num;
            b = den;
            while (b != '0) begin
               t = a % b;
               a = b;
               b = t;
            end
            r.numerator   = num / a;
            r.denominator = den / a;
            r.divisor     = a;
            r.bad_operand = 1'b0;
         end
         return r;
      endfunction

      function int pending();
         return expected_reductions.size();
      endfunction

      function void note_request(logic [frg_pkg::REQ_DATA_WIDTH-1:0] data);
         expected_reductions.push_back(reduce_fraction(
            data[frg_pkg::VALUE_WIDTH-1:0],
            data[2*frg_pkg::VALUE_WIDTH-1:frg_pkg::VALUE_WIDTH]));
      endfunction

      task report(string what, longint got, longint want);
         $display("mismatch %s: got 0x%0h, expected 0x%0h", what, got, want);
         error_count++;
      endtask

      task check_result(logic [frg_pkg::RSP_DATA_WIDTH-1:0] data, logic bad);
         reduced_fraction_type want;
         frg_pkg::value_type   got_num;
         frg_pkg::value_type   got_den;
         frg_pkg::value_type   got_div;
         got_num = data[frg_pkg::VALUE_WIDTH-1:0];
         got_den = data[2*frg_pkg::VALUE_WIDTH-1:frg_pkg::VALUE_WIDTH];
         got_div = data[3*frg_pkg::VALUE_WIDTH-1:2*frg_pkg::VALUE_WIDTH];
         if (expected_reductions.size() == 0) begin
            report("unexpected word", data, 0);
         end else begin
            want = expected_reductions.pop_front();
            if (got_num !== want.numerator) report("reduced_numerator", got_num, want.numerator);
            if (got_den !== want.denominator)
               report("reduced_denominator", got_den, want.denominator);
            if (got_div !== want.divisor) report("common_divisor", got_div, want.divisor);
            if (bad !== want.bad_operand) report("bad_operand", bad, want.bad_operand);
         end
      endtask
   endclass

   logic                               clock = 1'b0;
   logic                               reset = 1'b1;
   logic                               req_tvalid = 1'b0;
   logic                               req_tready;
   logic [frg_pkg::REQ_DATA_WIDTH-1:0] req_tdata = '0;
   logic                               rsp_tvalid;
   logic                               rsp_tready = 1'b0;
   logic [frg_pkg::RSP_DATA_WIDTH-1:0] rsp_tdata;
   logic                               rsp_tuser;

   reduction_scoreboard scoreboard = new();

   fraction_reduce_gcd_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) scoreboard.note_request(req_tdata);
         if (rsp_tvalid && rsp_tready) scoreboard.check_result(rsp_tdata, rsp_tuser);
      end
   end

   // receiver: changing stall patterns plus one long hold-off to back up the core
   initial begin
      int cycle;
      int mode;
      cycle = 0;
      mode  = 0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         cycle++;
         if (cycle % 150 == 0) mode = $urandom_range(0, 4);
         if (cycle >= 3000 && cycle < 3400) begin
            rsp_tready <= 1'b0;
         end else begin
            case (mode)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= ($urandom_range(0, 1) != 0);
               2: rsp_tready <= ($urandom_range(0, 3) == 0);
               3: rsp_tready <= ((cycle % 11) < 4);
               default: rsp_tready <= ($urandom_range(0, 7) != 0);
            endcase
         end
         @(posedge clock);
      end
   end

   task send_fraction(frg_pkg::value_type num, frg_pkg::value_type den);
      req_tvalid <= 1'b1;
      req_tdata  <= {den, num};
      do @(posedge clock); while (!req_tready);
   endtask

   task idle_sender(int cycles);
      req_tvalid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task wait_drained();
      while (scoreboard.pending() != 0) @(posedge clock);
   endtask

   task make_operands(output frg_pkg::value_type num, output frg_pkg::value_type den);
      int g;
      case ($urandom_range(0, 11))
         0, 1, 2: begin
            num = frg_pkg::value_type'($urandom);
            den = frg_pkg::value_type'($urandom);
         end
         3, 4, 5: begin
            // shared small factor
            g   = $urandom_range(1, 255);
            num = frg_pkg::value_type'(g * $urandom_range(1, 65535 / g));
            den = frg_pkg::value_type'(g * $urandom_range(1, 65535 / g));
         end
         6: begin
            // large shared factor
            g   = $urandom_range(1, 65535);
            num = frg_pkg::value_type'(g * $urandom_range(1, 65535 / g));
            den = frg_pkg::value_type'(g * $urandom_range(1, 65535 / g));
         end
         7: begin
            // zero operand
            case ($urandom_range(0, 2))
               0: begin num = '0; den = frg_pkg::value_type'($urandom); end
               1: begin num = frg_pkg::value_type'($urandom); den = '0; end
               default: begin num = '0; den = '0; end
            endcase
         end
         8: begin
            num = frg_pkg::value_type'($urandom_range(1, 255)) << $urandom_range(0, 8);
            den = frg_pkg::value_type'($urandom_range(1, 255)) << $urandom_range(0, 8);
         end
         9: begin
            num = frg_pkg::value_type'($urandom);
            den = num;
         end
         10: begin
            num = frg_pkg::value_type'($urandom_range(0, 16));
            den = frg_pkg::value_type'($urandom_range(0, 16));
         end
         default: begin
            num = ($urandom_range(0, 1) != 0) ? 16'hffff : 16'h0001;
            den = frg_pkg::value_type'($urandom);
            if ($urandom_range(0, 1) != 0) {num, den} = {den, num};
         end
      endcase
   endtask

   initial begin
      frg_pkg::value_type directed_num[$];
      frg_pkg::value_type directed_den[$];
      frg_pkg::value_type num;
      frg_pkg::value_type den;
      int                 sent;
      int                 burst;
      directed_num = '{16'd0, 16'd0, 16'd7, 16'd1, 16'hffff, 16'hffff, 16'd1, 16'd0,
                       16'hffff, 16'h8000, 16'd12, 16'h8000, 16'hfffe, 16'd6, 16'hffff,
                       16'h8000, 16'd1, 16'd46368, 16'd65535, 16'hf0f0, 16'd2};
      directed_den = '{16'd0, 16'd5, 16'd0, 16'd1, 16'hffff, 16'd1, 16'hffff, 16'hffff,
                       16'd0, 16'h4000, 16'd18, 16'h8000, 16'hffff, 16'd4, 16'd255,
                       16'd1, 16'h8000, 16'd28657, 16'd21845, 16'h0f0f, 16'd65534};
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      foreach (directed_num[i]) send_fraction(directed_num[i], directed_den[i]);
      idle_sender(1);
      wait_drained();

      sent = 0;
      while (sent < 1150) begin
         burst = $urandom_range(1, 12);
         repeat (burst) begin
            make_operands(num, den);
            send_fraction(num, den);
            sent++;
         end
         if (sent % 300 < burst) begin
            // let everything drain with the sender quiet
            idle_sender(1);
            wait_drained();
         end else if ($urandom_range(0, 3) != 0) begin
            idle_sender($urandom_range(1, 20));
         end
      end
      idle_sender(1);
      wait_drained();
      repeat (60) @(posedge clock);
      if (scoreboard.pending() != 0) scoreboard.report("words never returned",
                                                        scoreboard.pending(), 0);
      if (scoreboard.error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   initial begin
      #4_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule
